@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/itp_pkg.sv @@
// ---------------------------------------------------------------------------
// itp_pkg
// Types, codes and helpers for the infix to postfix converter.
// ---------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

  // input token kinds
  localparam logic [2:0] TK_NUM    = 3'd0;
  localparam logic [2:0] TK_VAR    = 3'd1;
  localparam logic [2:0] TK_OP     = 3'd2;
  localparam logic [2:0] TK_LPAREN = 3'd3;
  localparam logic [2:0] TK_RPAREN = 3'd4;

  // operator codes; stack also holds a left paren code
  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_SUB      = 3'd1;
  localparam logic [2:0] OP_MUL      = 3'd2;
  localparam logic [2:0] OP_DIV      = 3'd3;
  localparam logic [2:0] OP_POW      = 3'd4;
  localparam logic [2:0] LPAREN_CODE = 3'd5;

  // result kinds
  localparam logic [2:0] RK_NUM = 3'd0;
  localparam logic [2:0] RK_VAR = 3'd1;
  localparam logic [2:0] RK_OP  = 3'd2;
  localparam logic [2:0] RK_END = 3'd3;
  localparam logic [2:0] RK_ERR = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [1:0] ST_UNMATCH_RP = 2'd2;
  localparam logic [1:0] ST_UNMATCH_LP = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EVAL,
    S_PUSH,
    S_PASS,
    S_UNMATCH_R,
    S_FLUSH_ERR,
    S_FLUSH_END,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  op;
    logic [31:0] payload;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       rd;
    logic [2:0] wdata;
  } stk_ctl_t;

  typedef struct packed {
    logic stage;
    logic finish;
  } outq_ctl_t;

  // binding level; left paren and unknown codes are level 0
  function automatic logic [1:0] level_of(input logic [2:0] code);
    logic [1:0] lv;
    case (code)
      OP_ADD, OP_SUB: lv = 2'd1;
      OP_MUL, OP_DIV: lv = 2'd2;
      OP_POW:         lv = 2'd3;
      default:        lv = 2'd0;
    endcase
    return lv;
  endfunction

endpackage

@@ hdl/itp_stack.sv @@
// ---------------------------------------------------------------------------
// itp_stack
// Operator stack: memory with registered top read and an entry count.
// ---------------------------------------------------------------------------
module itp_stack
  import itp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  stk_ctl_t          ctl,
  output logic [STK_CW-1:0] count,
  output logic [2:0]        top,
  output logic              full
);

  logic [2:0]        mem [STACK_DEPTH];
  logic [STK_CW-1:0] count_r, count_nxt;
  logic [2:0]        top_r;
  logic [STK_CW-1:0] rd_idx;

  // a read issued together with a pop fetches the entry below the popped one
  assign rd_idx = count_r - (ctl.pop ? STK_CW'(2) : STK_CW'(1));

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + STK_CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - STK_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[count_r[STK_AW-1:0]] <= ctl.wdata;
    end
    if (ctl.rd) begin
      top_r <= mem[rd_idx[STK_AW-1:0]];
    end
  end

  assign count = count_r;
  assign top   = top_r;
  assign full  = (count_r == STK_CW'(STACK_DEPTH));

endmodule

@@ hdl/itp_outq.sv @@
// ---------------------------------------------------------------------------
// itp_outq
// Staging slot plus output register; marks the final result of a transaction.
// ---------------------------------------------------------------------------
module itp_outq
  import itp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  outq_ctl_t   ctl,
  input  res_t        res,
  output logic        room,
  output logic        pend_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_op,
  output logic [31:0] out_payload,
  output logic [1:0]  out_status,
  output logic        out_last
);

  res_t pend_r;
  logic pend_v_r, pend_v_nxt;
  res_t out_r;
  logic out_last_r, out_last_nxt;
  logic out_v_r, out_v_nxt;
  logic load_out;

  // staged result can move on when the output slot is free or draining
  assign room = !pend_v_r || !out_v_r || out_ready;

  always_comb begin
    out_v_nxt    = out_v_r && !out_ready;
    pend_v_nxt   = pend_v_r;
    load_out     = 1'b0;
    out_last_nxt = out_last_r;
    if (ctl.stage) begin
      pend_v_nxt = 1'b1;
      if (pend_v_r) begin
        load_out     = 1'b1;
        out_last_nxt = 1'b0;
      end
    end else if (ctl.finish) begin
      pend_v_nxt = 1'b0;
      if (pend_v_r) begin
        load_out     = 1'b1;
        out_last_nxt = 1'b1;
      end
    end
    if (load_out) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.stage) begin
      pend_r <= res;
    end
    if (load_out) begin
      out_r      <= pend_r;
      out_last_r <= out_last_nxt;
    end
  end

  assign pend_valid  = pend_v_r;
  assign out_valid   = out_v_r;
  assign out_kind    = out_r.kind;
  assign out_op      = out_r.op;
  assign out_payload = out_r.payload;
  assign out_status  = out_r.status;
  assign out_last    = out_last_r;

endmodule

@@ hdl/infix_to_postfix_converter.sv @@
// ---------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix token stream in, postfix result stream out.
// ---------------------------------------------------------------------------
// One transaction at a time. After a token is taken the block drops in_ready
// and a small sequencer walks the operator stack, one stack entry per cycle
// while the output has room, through a single precedence compare; the stack
// memory has one registered read port, so the top entry is read in S_DISPATCH
// before S_EVAL compares it. An operator pops until a looser top (for power,
// no tighter) or an empty stack and is pushed; a closing paren pops operators
// up to its left paren; an end transaction flushes the whole stack, then gives
// an error result if a left paren was dropped, and the end marker.
// Each result passes through a one-entry staging slot so that out_last can be
// set on the final result of the transaction, then an output register; a
// stalled out_ready holds the sequencer where it would emit.
// Stack overflow, an unmatched right paren and leftover left parens at end
// are reported with an error result carrying out_status.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // token input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [2:0]  in_token_kind,
  input  logic [2:0]  in_op_code,
  input  logic [31:0] in_payload,
  // postfix output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_op,
  output logic [31:0] out_payload,
  output logic [1:0]  out_status,
  output logic        out_last
);

  seq_state_t state_r, state_nxt;

  // latched transaction
  logic        cmd_r;
  logic [2:0]  kind_r;
  logic [2:0]  op_r;
  logic [31:0] payload_r;
  logic        paren_r, paren_nxt;   // left paren dropped during flush

  // stack
  stk_ctl_t          stk_ctl;
  logic [STK_CW-1:0] stk_count;
  logic [2:0]        stk_top;
  logic              stk_full;

  // output queue
  outq_ctl_t q_ctl;
  res_t      q_res;
  logic      q_room;
  logic      q_pend;

  // shared compare: does the stacked operator bind tightly enough to pop?
  logic [1:0] lv_in, lv_top;
  logic       top_pops;
  logic       top_lp;
  logic       more;

  assign lv_in    = level_of(op_r);
  assign lv_top   = level_of(stk_top);
  // power is right-associative: pop only on strictly higher level
  assign top_pops = (op_r == OP_POW) ? (lv_in < lv_top) : (lv_in <= lv_top);
  assign top_lp   = (stk_top == LPAREN_CODE);
  assign more     = (stk_count > STK_CW'(1));

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    paren_nxt = paren_r;
    stk_ctl   = '0;
    q_ctl     = '0;
    q_res     = '0;

    case (state_r)
      S_IDLE: begin
        paren_nxt = 1'b0;
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (cmd_r) begin
          if (stk_count != '0) begin
            stk_ctl.rd = 1'b1;
            state_nxt  = S_EVAL;
          end else begin
            state_nxt = S_FLUSH_END;
          end
        end else begin
          case (kind_r)
            TK_NUM, TK_VAR: state_nxt = S_PASS;
            TK_OP: begin
              if (op_r > OP_POW) begin
                state_nxt = S_IDLE;           // unknown operator: dropped
              end else if (stk_count != '0) begin
                stk_ctl.rd = 1'b1;
                state_nxt  = S_EVAL;
              end else begin
                state_nxt = S_PUSH;
              end
            end
            TK_LPAREN: state_nxt = S_PUSH;
            TK_RPAREN: begin
              if (stk_count != '0) begin
                stk_ctl.rd = 1'b1;
                state_nxt  = S_EVAL;
              end else begin
                state_nxt = S_UNMATCH_R;
              end
            end
            default: state_nxt = S_IDLE;     // unknown kind: dropped
          endcase
        end
      end

      // stk_top holds the current top entry
      S_EVAL: begin
        q_res.kind = RK_OP;
        q_res.op   = stk_top;
        if (cmd_r) begin
          if (top_lp) begin
            stk_ctl.pop = 1'b1;
            paren_nxt   = 1'b1;
            if (more) begin
              stk_ctl.rd = 1'b1;
            end else begin
              state_nxt = S_FLUSH_ERR;
            end
          end else if (q_room) begin
            q_ctl.stage = 1'b1;
            stk_ctl.pop = 1'b1;
            if (more) begin
              stk_ctl.rd = 1'b1;
            end else begin
              state_nxt = paren_r ? S_FLUSH_ERR : S_FLUSH_END;
            end
          end
        end else if (kind_r == TK_OP) begin
          if (!top_pops) begin
            state_nxt = S_PUSH;
          end else if (q_room) begin
            q_ctl.stage = 1'b1;
            stk_ctl.pop = 1'b1;
            if (more) begin
              stk_ctl.rd = 1'b1;
            end else begin
              state_nxt = S_PUSH;
            end
          end
        end else begin
          // right paren
          if (top_lp) begin
            stk_ctl.pop = 1'b1;
            state_nxt   = S_FINISH;
          end else if (q_room) begin
            q_ctl.stage = 1'b1;
            stk_ctl.pop = 1'b1;
            if (more) begin
              stk_ctl.rd = 1'b1;
            end else begin
              state_nxt = S_UNMATCH_R;
            end
          end
        end
      end

      S_PUSH: begin
        q_res.kind   = RK_ERR;
        q_res.status = ST_OVERFLOW;
        if (stk_full) begin
          if (q_room) begin
            q_ctl.stage = 1'b1;
            state_nxt   = S_FINISH;
          end
        end else begin
          stk_ctl.push  = 1'b1;
          stk_ctl.wdata = (kind_r == TK_OP) ? op_r : LPAREN_CODE;
          state_nxt     = S_FINISH;
        end
      end

      S_PASS: begin
        q_res.kind    = kind_r;
        q_res.payload = payload_r;
        if (q_room) begin
          q_ctl.stage = 1'b1;
          state_nxt   = S_FINISH;
        end
      end

      S_UNMATCH_R: begin
        q_res.kind   = RK_ERR;
        q_res.status = ST_UNMATCH_RP;
        if (q_room) begin
          q_ctl.stage = 1'b1;
          state_nxt   = S_FINISH;
        end
      end

      S_FLUSH_ERR: begin
        q_res.kind   = RK_ERR;
        q_res.status = ST_UNMATCH_LP;
        if (q_room) begin
          q_ctl.stage = 1'b1;
          state_nxt   = S_FLUSH_END;
        end
      end

      S_FLUSH_END: begin
        q_res.kind = RK_END;
        if (q_room) begin
          q_ctl.stage = 1'b1;
          state_nxt   = S_FINISH;
        end
      end

      // push the staged result out with out_last set
      S_FINISH: begin
        if (q_room) begin
          q_ctl.finish = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      paren_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      paren_r <= paren_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r     <= in_cmd;
      kind_r    <= in_token_kind;
      op_r      <= in_op_code;
      payload_r <= in_payload;
    end
  end

  itp_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .count (stk_count),
    .top   (stk_top),
    .full  (stk_full)
  );

  itp_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (q_ctl),
    .res         (q_res),
    .room        (q_room),
    .pend_valid  (q_pend),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_op      (out_op),
    .out_payload (out_payload),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  // sequencer never pushes into a full stack or pops an empty one
  `AST_IMP(a_push_room, clk, rst_n, stk_ctl.push, !stk_full)
  `AST_IMP(a_pop_nonempty, clk, rst_n, stk_ctl.pop, stk_count != '0)
  // a transaction is fully handed to the output register before the next
  `AST_IMP(a_idle_drained, clk, rst_n, in_ready, !q_pend)
  `AST_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

@@ tb/tb_infix_to_postfix_converter.sv @@
// ---------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Self-checking bench for the shunting-yard infix to postfix converter.
// ---------------------------------------------------------------------------
// A token stream is driven into the block with random gaps. A directed table
// comes first, then random expressions, deep nesting runs and junk tokens. A
// local operator stack model predicts the postfix transactions for every
// accepted token. The output side stalls at random, with two long holds that
// back the block up into its input. Each output transaction is compared field
// by field against the oldest pending prediction.
// ---------------------------------------------------------------------------
module tb_infix_to_postfix_converter;
  import itp_pkg::*;

  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         DRAIN_CYCLES = 64;     // covers a full 32-deep flush
  localparam int         TOTAL_ITEMS  = 310;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         PLAN_ROWS    = 22;
  // out-of-range codes, used to prove the block ignores them
  localparam logic [2:0] TK_UNKNOWN   = 3'd7;
  localparam logic [2:0] OP_UNKNOWN   = 3'd7;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  kind;
    logic [2:0]  op;
    logic [31:0] payload;
  } token_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  op;
    logic [31:0] payload;
    logic [1:0]  status;
    logic        last;
  } postfix_t;

  // Directed stimulus row. When fixed is set, want is the single transaction
  // the token must produce; otherwise the stack model supplies the prediction.
  typedef struct packed {
    token_t   tok;
    logic     fixed;
    postfix_t want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [2:0]  in_token_kind;
  logic [2:0]  in_op_code;
  logic [31:0] in_payload;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [2:0]  out_op;
  logic [31:0] out_payload;
  logic [1:0]  out_status;
  logic        out_last;

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  logic        quiet_tx     = 1'b0;

  // operator stack model and its fill level
  logic [2:0]  opstk [STACK_DEPTH];
  int unsigned stk_fill = 0;

  postfix_t    step_out[$];    // transactions caused by the current token
  postfix_t    postfix_q[$];   // predictions not yet matched by the block
  token_t      burst_q[$];     // token sequence being built for the sender
  plan_row_t   plan [PLAN_ROWS];

  infix_to_postfix_converter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_token_kind (in_token_kind),
    .in_op_code    (in_op_code),
    .in_payload    (in_payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_op        (out_op),
    .out_payload   (out_payload),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stack model
  // -------------------------------------------------------------------------

  // Binding strength; a left paren (and anything unknown) binds loosest.
  function automatic logic [1:0] prec_of(input logic [2:0] code);
    logic [1:0] lv;
    case (code)
      OP_ADD, OP_SUB: lv = 2'd1;
      OP_MUL, OP_DIV: lv = 2'd2;
      OP_POW:         lv = 2'd3;
      default:        lv = 2'd0;
    endcase
    return lv;
  endfunction

  function automatic void emit_postfix(input logic [2:0] kind, input logic [2:0] op,
                                       input logic [31:0] pl, input logic [1:0] st);
    postfix_t r;
    r.kind    = kind;
    r.op      = op;
    r.payload = pl;
    r.status  = st;
    r.last    = 1'b0;
    step_out.push_back(r);
  endfunction

  // A push onto a full stack drops the code and flags an overflow.
  function automatic void stack_push(input logic [2:0] code);
    if (stk_fill >= STACK_DEPTH) begin
      emit_postfix(RK_ERR, OP_ADD, '0, ST_OVERFLOW);
    end else begin
      opstk[stk_fill] = code;
      stk_fill++;
    end
  endfunction

  // Advances the model by one token and leaves its transactions in step_out.
  function automatic void convert_token(input token_t t);
    logic       paren_left;
    logic       matched;
    logic       stop;
    logic [2:0] top;
    postfix_t   r;
    step_out.delete();
    if (t.cmd) begin
      // end of expression: flush everything, leftover '(' is an error
      paren_left = 1'b0;
      while (stk_fill > 0) begin
        stk_fill--;
        top = opstk[stk_fill];
        if (top == LPAREN_CODE) paren_left = 1'b1;
        else emit_postfix(RK_OP, top, '0, ST_OK);
      end
      if (paren_left) emit_postfix(RK_ERR, OP_ADD, '0, ST_UNMATCH_LP);
      emit_postfix(RK_END, OP_ADD, '0, ST_OK);
    end else begin
      case (t.kind)
        TK_NUM: emit_postfix(RK_NUM, OP_ADD, t.payload, ST_OK);
        TK_VAR: emit_postfix(RK_VAR, OP_ADD, t.payload, ST_OK);
        TK_OP: begin
          if (t.op <= OP_POW) begin
            stop = 1'b0;
            while (stk_fill > 0 && !stop) begin
              top = opstk[stk_fill - 1];
              // power is right-associative: only strictly tighter ops pop
              if ((t.op == OP_POW) ? (prec_of(t.op) < prec_of(top))
                                   : (prec_of(t.op) <= prec_of(top))) begin
                emit_postfix(RK_OP, top, '0, ST_OK);
                stk_fill--;
              end else begin
                stop = 1'b1;
              end
            end
            stack_push(t.op);
          end
        end
        TK_LPAREN: stack_push(LPAREN_CODE);
        TK_RPAREN: begin
          matched = 1'b0;
          while (stk_fill > 0 && !matched) begin
            stk_fill--;
            top = opstk[stk_fill];
            if (top == LPAREN_CODE) matched = 1'b1;
            else emit_postfix(RK_OP, top, '0, ST_OK);
          end
          if (!matched) emit_postfix(RK_ERR, OP_ADD, '0, ST_UNMATCH_RP);
        end
        default: ;
      endcase
    end
    if (step_out.size() > 0) begin
      r = step_out[step_out.size() - 1];
      r.last = 1'b1;
      step_out[step_out.size() - 1] = r;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------

  function automatic void compare_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: out_%s mismatch: expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
      mismatch_cnt++;
    end
  endfunction

  function automatic void check_postfix(input postfix_t got);
    postfix_t want;
    if (postfix_q.size() == 0) begin
      $display("%0t: transaction with nothing pending: kind %0d op %0d payload 0x%0h",
               $time, got.kind, got.op, got.payload);
      mismatch_cnt++;
      return;
    end
    want = postfix_q.pop_front();
    compare_field("kind", 32'(want.kind), 32'(got.kind));
    compare_field("op", 32'(want.op), 32'(got.op));
    compare_field("payload", want.payload, got.payload);
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("last", 32'(want.last), 32'(got.last));
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus builders
  // -------------------------------------------------------------------------

  function automatic token_t mk_tok(input logic cmd, input logic [2:0] kind,
                                    input logic [2:0] op, input logic [31:0] pl);
    token_t t;
    t.cmd     = cmd;
    t.kind    = kind;
    t.op      = op;
    t.payload = pl;
    return t;
  endfunction

  function automatic postfix_t mk_res(input logic [2:0] kind, input logic [31:0] pl,
                                      input logic [1:0] st);
    postfix_t r;
    r.kind    = kind;
    r.op      = OP_ADD;
    r.payload = pl;
    r.status  = st;
    r.last    = 1'b1;
    return r;
  endfunction

  // Unused fields carry random junk so every input bit gets toggled.
  function automatic token_t rand_tok(input logic [2:0] kind, input logic [2:0] op);
    return mk_tok(1'b0, kind, op, $urandom());
  endfunction

  function automatic token_t rand_operand();
    return rand_tok($urandom_range(0, 1) ? TK_VAR : TK_NUM, 3'($urandom_range(0, 7)));
  endfunction

  function automatic token_t rand_end();
    return mk_tok(1'b1, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom());
  endfunction

  // Well-formed infix with random operators and nesting; now and then a paren
  // is left open or one closes too many.
  function automatic void build_expression();
    int unsigned n_opnd;
    int unsigned open;
    n_opnd = $urandom_range(1, 8);
    open   = 0;
    for (int i = 0; i < n_opnd; i++) begin
      while (open < 6 && $urandom_range(0, 3) == 0) begin
        burst_q.push_back(rand_tok(TK_LPAREN, 3'($urandom_range(0, 7))));
        open++;
      end
      burst_q.push_back(rand_operand());
      while (open > 0 && $urandom_range(0, 2) == 0) begin
        burst_q.push_back(rand_tok(TK_RPAREN, 3'($urandom_range(0, 7))));
        open--;
      end
      if (i + 1 < n_opnd) burst_q.push_back(rand_tok(TK_OP, 3'($urandom_range(0, 4))));
    end
    if ($urandom_range(0, 9) != 0) begin
      while (open > 0) begin
        burst_q.push_back(rand_tok(TK_RPAREN, 3'($urandom_range(0, 7))));
        open--;
      end
    end
    if ($urandom_range(0, 9) == 0)
      burst_q.push_back(rand_tok(TK_RPAREN, 3'($urandom_range(0, 7))));
    burst_q.push_back(rand_end());
  endfunction

  // Power chains and open parens never pop, so this pushes 28 to 36 entries,
  // filling the 32-deep stack to near its brim and sometimes past it.
  function automatic void build_deep();
    int unsigned n_push;
    int unsigned n_close;
    n_push = $urandom_range(28, 36);
    for (int i = 0; i < n_push; i++) begin
      if ($urandom_range(0, 1)) begin
        burst_q.push_back(rand_tok(TK_LPAREN, 3'($urandom_range(0, 7))));
      end else begin
        burst_q.push_back(rand_operand());
        burst_q.push_back(rand_tok(TK_OP, OP_POW));
      end
    end
    burst_q.push_back(rand_operand());
    n_close = $urandom_range(0, 4);
    repeat (n_close) burst_q.push_back(rand_tok(TK_RPAREN, 3'($urandom_range(0, 7))));
    burst_q.push_back(rand_end());
  endfunction

  // Junk: any field value, including unknown kinds and operator codes.
  function automatic void build_noise();
    int unsigned n_tok;
    n_tok = $urandom_range(3, 10);
    repeat (n_tok)
      burst_q.push_back(mk_tok($urandom_range(0, 7) == 0, 3'($urandom_range(0, 7)),
                               3'($urandom_range(0, 7)), $urandom()));
    if ($urandom_range(0, 1)) burst_q.push_back(rand_end());
  endfunction

  // Directed table: edge payloads, every operator, both associativities,
  // both unmatched-paren error statuses and the ignored codes.
  function automatic void load_plan();
    plan[0]  = '{mk_tok(1'b0, TK_NUM, OP_ADD, 32'h0), 1'b1,
                 mk_res(RK_NUM, 32'h0, ST_OK)};
    plan[1]  = '{mk_tok(1'b0, TK_VAR, OP_POW, 32'hFFFF_FFFF), 1'b1,
                 mk_res(RK_VAR, 32'hFFFF_FFFF, ST_OK)};
    // ')' on an empty stack
    plan[2]  = '{mk_tok(1'b0, TK_RPAREN, OP_ADD, 32'h0), 1'b1,
                 mk_res(RK_ERR, 32'h0, ST_UNMATCH_RP)};
    // end on an empty stack gives the end marker alone
    plan[3]  = '{mk_tok(1'b1, TK_NUM, OP_ADD, 32'h0), 1'b1,
                 mk_res(RK_END, 32'h0, ST_OK)};
    // ( 1 + 2 * v3 - 4 ^ 5 ^ v6 ) / (  -> the rest is checked by the model
    plan[4]  = '{mk_tok(1'b0, TK_LPAREN, OP_ADD, 32'h0), 1'b0, '0};
    plan[5]  = '{mk_tok(1'b0, TK_NUM, OP_ADD, 32'h1), 1'b0, '0};
    plan[6]  = '{mk_tok(1'b0, TK_OP, OP_ADD, 32'h0), 1'b0, '0};
    plan[7]  = '{mk_tok(1'b0, TK_NUM, OP_ADD, 32'h2), 1'b0, '0};
    plan[8]  = '{mk_tok(1'b0, TK_OP, OP_MUL, 32'h0), 1'b0, '0};
    plan[9]  = '{mk_tok(1'b0, TK_VAR, OP_ADD, 32'h3), 1'b0, '0};
    plan[10] = '{mk_tok(1'b0, TK_OP, OP_SUB, 32'h0), 1'b0, '0};
    plan[11] = '{mk_tok(1'b0, TK_NUM, OP_ADD, 32'h4), 1'b0, '0};
    plan[12] = '{mk_tok(1'b0, TK_OP, OP_POW, 32'h0), 1'b0, '0};
    plan[13] = '{mk_tok(1'b0, TK_NUM, OP_ADD, 32'h5), 1'b0, '0};
    plan[14] = '{mk_tok(1'b0, TK_OP, OP_POW, 32'h0), 1'b0, '0};
    plan[15] = '{mk_tok(1'b0, TK_VAR, OP_ADD, 32'h6), 1'b0, '0};
    plan[16] = '{mk_tok(1'b0, TK_RPAREN, OP_ADD, 32'h0), 1'b0, '0};
    plan[17] = '{mk_tok(1'b0, TK_OP, OP_DIV, 32'h0), 1'b0, '0};
    plan[18] = '{mk_tok(1'b0, TK_LPAREN, OP_ADD, 32'h0), 1'b0, '0};
    plan[19] = '{mk_tok(1'b0, TK_OP, OP_UNKNOWN, 32'hDEAD_BEEF), 1'b0, '0};
    plan[20] = '{mk_tok(1'b0, TK_UNKNOWN, OP_ADD, 32'h1234_5678), 1'b0, '0};
    // end with '(' still stacked: flush, unmatched-left error, end marker
    plan[21] = '{mk_tok(1'b1, TK_RPAREN, OP_POW, 32'hA5A5_A5A5), 1'b0, '0};
  endfunction

  // -------------------------------------------------------------------------
  // Token driver: called at a falling edge, returns at a falling edge.
  // -------------------------------------------------------------------------
  task automatic offer(input token_t t, input logic fixed, input postfix_t want);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 39) == 0) quiet_tx = !quiet_tx;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= t.cmd;
    in_token_kind <= t.kind;
    in_op_code    <= t.op;
    in_payload    <= t.payload;
    do @(posedge clk); while (!in_ready);
    // accepted on this edge: advance the model and queue its transactions
    convert_token(t);
    if (fixed) postfix_q.push_back(want);
    else foreach (step_out[i]) postfix_q.push_back(step_out[i]);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned counted;
    int unsigned pick;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = 1'b0;
    in_token_kind = TK_NUM;
    in_op_code    = OP_ADD;
    in_payload    = '0;
    counted       = PLAN_ROWS;
    load_plan();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) offer(plan[i].tok, plan[i].fixed, plan[i].want);

    // Mostly well-formed expressions, with deep runs and junk mixed in.
    while (counted < TOTAL_ITEMS) begin
      burst_q.delete();
      pick = $urandom_range(0, 9);
      if (pick < 7) build_expression();
      else if (pick < 8) build_deep();
      else build_noise();
      foreach (burst_q[i]) begin
        offer(burst_q[i], 1'b0, '0);
        counted++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then give a stray transaction time to show up.
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Postfix receiver: random stalls, quiet stretches, and two long holds so
  // the block backs up and drops in_ready while tokens keep coming.
  // -------------------------------------------------------------------------
  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    logic        quiet_rx;
    postfix_t    got;
    out_ready = 1'b0;
    taken     = 0;
    quiet_rx  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (taken == 80 || taken == 250) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = quiet_rx ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.kind    = out_kind;
      got.op      = out_op;
      got.payload = out_payload;
      got.status  = out_status;
      got.last    = out_last;
      check_postfix(got);
      taken++;
    end
  end

endmodule
